### design/two_class_fifo_oldest_first_unit_macros.svh
// Assertion macros shared by the two-class FIFO RTL.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define TCFO_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define TCFO_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCFO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tcfo_pkg.sv
// ----------------------------------------------------------------------------
// Two-class FIFO package
// Shared constants, entry and status types, ring pointer helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfo_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STAMP_W     = 9;
  localparam int VAL_W       = 8;

  localparam logic signed [15:0] VALUE_MAX = 16'sd99;
  localparam logic signed [15:0] VALUE_MIN = -16'sd99;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_ADOPT = 1'b1;

  localparam logic signed [15:0] SEL_ANY = 16'sd0;
  localparam logic signed [15:0] SEL_A   = 16'sd1;
  localparam logic signed [15:0] SEL_B   = -16'sd1;

  typedef struct packed {
    logic [STAMP_W-1:0]      stamp;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_status_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
    return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

`default_nettype wire

### design/tcfo_ring.sv
// ----------------------------------------------------------------------------
// Ring queue
// One class queue: RAM ring with show-ahead head register and write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_fifo_oldest_first_unit_macros.svh"

module tcfo_ring (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire tcfo_pkg::entry_t      push_data,
  input  wire logic                  pop,
  output tcfo_pkg::entry_t           head,
  output tcfo_pkg::ring_status_t     status
);

  tcfo_pkg::entry_t                  mem [tcfo_pkg::QUEUE_DEPTH];
  logic [tcfo_pkg::PTR_W-1:0]        head_r, head_nxt;
  logic [tcfo_pkg::PTR_W-1:0]        tail_r, tail_nxt;
  logic [tcfo_pkg::CNT_W-1:0]        count_r, count_nxt;
  tcfo_pkg::entry_t                  rd_r;
  tcfo_pkg::entry_t                  byp_data_r;
  logic                              byp_r;

  always_comb begin
    head_nxt  = pop  ? tcfo_pkg::next_slot(head_r) : head_r;
    tail_nxt  = push ? tcfo_pkg::next_slot(tail_r) : tail_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      byp_r   <= push && (tail_r == head_nxt);
    end
  end

  // RAM: one write at tail, one registered read at the next head
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    rd_r       <= mem[head_nxt];
    byp_data_r <= push_data;
  end

  // a write landing on the slot being read forwards its data
  assign head         = byp_r ? byp_data_r : rd_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == tcfo_pkg::CNT_W'(tcfo_pkg::QUEUE_DEPTH));

  `TCFO_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n,
    count_r <= tcfo_pkg::CNT_W'(tcfo_pkg::QUEUE_DEPTH), "ring count beyond depth")
  `TCFO_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, !status.empty, "pop from empty ring")
  `TCFO_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, !status.full, "push into full ring")
  `TCFO_ASSERT_NEXT(a_push_count, clk, rst_n, push && !pop,
    count_r == $past(count_r) + 1'b1, "count did not follow push")

endmodule

`default_nettype wire

### design/two_class_fifo_oldest_first_unit.sv
// ----------------------------------------------------------------------------
// Two-class FIFO, oldest first: two rings sharing one arrival order.
// Results go to the output register, or to the skid while an earlier one stalls.
// Throughput 1 request per cycle; in_ready drops only when output and skid are full.
// Reset: synchronous active-low clears pointers, counts, arrival counter, valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_class_fifo_oldest_first_unit_macros.svh"

module two_class_fifo_oldest_first_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [7:0]       out_pet_value,
  output logic                    out_dropped
);

  logic                              in_fire, out_fire;
  logic                              in_range, is_add, is_adopt;
  logic                              add_a, add_b, push_a, push_b, pop_a, pop_b;
  logic                              drop, has_result, take_a;
  logic [tcfo_pkg::STAMP_W-1:0]      stamp_diff;
  logic [tcfo_pkg::STAMP_W-1:0]      arrival_r, arrival_nxt;
  tcfo_pkg::entry_t                  push_entry, head_a, head_b;
  tcfo_pkg::ring_status_t            st_a, st_b;
  logic signed [7:0]                 res_val;
  logic                              out_valid_r, skid_valid_r;
  logic signed [7:0]                 out_val_r, skid_val_r;
  logic                              out_drop_r, skid_drop_r;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign in_range = (in_value <= tcfo_pkg::VALUE_MAX) && (in_value >= tcfo_pkg::VALUE_MIN);
  assign is_add   = in_fire && in_range && (in_mode == tcfo_pkg::MODE_ADD);
  assign is_adopt = in_fire && in_range && (in_mode == tcfo_pkg::MODE_ADOPT);

  assign add_a  = is_add && (in_value > 16'sd0);
  assign add_b  = is_add && (in_value < 16'sd0);
  assign push_a = add_a && !st_a.full;
  assign push_b = add_b && !st_b.full;
  assign drop   = (add_a && st_a.full) || (add_b && st_b.full);

  // modular age order: zero or top bit set means A is the older head
  assign stamp_diff = head_a.stamp - head_b.stamp;
  assign take_a     = (stamp_diff == '0) || stamp_diff[tcfo_pkg::STAMP_W-1];

  assign pop_a = is_adopt && !st_a.empty &&
                 ((in_value == tcfo_pkg::SEL_A) ||
                  ((in_value == tcfo_pkg::SEL_ANY) && (st_b.empty || take_a)));
  assign pop_b = is_adopt && !st_b.empty &&
                 ((in_value == tcfo_pkg::SEL_B) ||
                  ((in_value == tcfo_pkg::SEL_ANY) && (st_a.empty || !take_a)));

  assign has_result = drop || pop_a || pop_b;
  assign res_val    = drop ? in_value[7:0] : (pop_a ? head_a.val : head_b.val);

  assign push_entry.stamp = arrival_r;
  assign push_entry.val   = in_value[7:0];
  assign arrival_nxt      = (push_a || push_b) ? arrival_r + 1'b1 : arrival_r;

  tcfo_ring u_ring_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_a),
    .push_data (push_entry),
    .pop       (pop_a),
    .head      (head_a),
    .status    (st_a)
  );

  tcfo_ring u_ring_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_b),
    .push_data (push_entry),
    .pop       (pop_b),
    .head      (head_b),
    .status    (st_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      arrival_r <= arrival_nxt;
      if (skid_valid_r) begin
        if (out_fire) begin
          skid_valid_r <= 1'b0;
        end
      end else if (has_result) begin
        if (out_valid_r && !out_fire) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_val_r  <= skid_val_r;
        out_drop_r <= skid_drop_r;
      end
    end else if (has_result) begin
      if (out_valid_r && !out_fire) begin
        skid_val_r  <= res_val;
        skid_drop_r <= drop;
      end else begin
        out_val_r  <= res_val;
        out_drop_r <= drop;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pet_value = out_val_r;
  assign out_dropped   = out_drop_r;

  `TCFO_ASSERT_ALWAYS(a_one_action, clk, rst_n,
    $countones({push_a, push_b, pop_a, pop_b, drop}) <= 1, "more than one queue action")
  `TCFO_ASSERT_IMPLIES(a_skid_order, clk, rst_n, skid_valid_r, out_valid_r,
    "skid holds a result ahead of the output register")
  `TCFO_ASSERT_NEXT(a_result_shown, clk, rst_n, has_result, out_valid_r,
    "result lost after transfer")
  `TCFO_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_r && !out_ready,
    out_valid_r && (out_val_r == $past(out_val_r)), "stalled result changed")

endmodule

`default_nettype wire
